FILE: hdl/bmfs_pkg.sv
package bmfs_pkg;

	// array geometry
	localparam int DEPTH      = 1024;
	localparam int BLOCK_LEN  = 32;
	localparam int NUM_BLOCKS = (DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;

	// derived widths
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int OFS_W  = $clog2(BLOCK_LEN);
	localparam int BLK_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] DEPTH_CNT     = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] BLOCK_LEN_CNT = CNT_W'(BLOCK_LEN);
	localparam logic [BLK_W-1:0] LAST_BLK      = BLK_W'(NUM_BLOCKS - 1);
	localparam logic [CNT_W-1:0] COUNT_RESET   = 11'd1024;

	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// sequencer states
	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_WRITE  = 7'b0000100,
		ST_RESCAN = 7'b0001000,
		ST_BSCAN  = 7'b0010000,
		ST_ESCAN  = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

endpackage

FILE: hdl/block_max_first_at_least_search_top.sv
// A write in use is stored, then its block is rescanned through the element memory port to rebuild
// the block maximum (only the positions in use within a block clipped by the count); other writes
// are dropped. A query walks the block maxima in order and scans each block whose maximum reaches
// the operand until an element hits; the result register then waits on out_stall. One beat in work.
// Reset: asynchronous, active low. After reset a clearing pass over all DEPTH elements fills the element
// memory with the most negative value; no input beat is taken until it ends.
module block_max_first_at_least_search_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [bmfs_pkg::CNT_W-1:0]            cfg_write_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  command,
	input  logic [bmfs_pkg::ADDR_W-1:0]           position,
	input  logic signed [bmfs_pkg::DATA_W-1:0]    operand_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic [bmfs_pkg::ADDR_W-1:0]           first_index
);

	localparam int ADDR_W = bmfs_pkg::ADDR_W;
	localparam int CNT_W  = bmfs_pkg::CNT_W;
	localparam int BLK_W  = bmfs_pkg::BLK_W;
	localparam int OFS_W  = bmfs_pkg::OFS_W;
	localparam int DATA_W = bmfs_pkg::DATA_W;

	bmfs_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]         count_q;
	logic                     cmd_q;
	logic [ADDR_W-1:0]        pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [BLK_W-1:0]         blk_q, blk_d;
	logic [CNT_W-1:0]         idx_q, idx_d;
	logic [CNT_W-1:0]         end_q, end_d;
	logic signed [DATA_W-1:0] max_q, max_d;
	logic                     hit_found_q, hit_found_d;
	logic [ADDR_W-1:0]        hit_idx_q, hit_idx_d;

	logic                     out_valid_q;
	logic                     found_q;
	logic [ADDR_W-1:0]        first_index_q;

	logic signed [DATA_W-1:0] elem_mem_q [bmfs_pkg::DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;
	logic                     pend_q;
	logic [ADDR_W-1:0]        tag_q;

	logic signed [DATA_W-1:0] bmax_q [bmfs_pkg::NUM_BLOCKS];

	logic                     in_accept;
	logic                     out_free;
	logic                     emit_load;
	logic [CNT_W-1:0]         lim;
	logic [CNT_W-1:0]         blk_lo;
	logic [CNT_W-1:0]         blk_hi;
	logic                     issue;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                     bmax_we;
	logic signed [DATA_W-1:0] cmp_a, cmp_b;
	logic                     cmp_ge;

	// handshake
	assign in_stall  = (state_q != bmfs_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_load = (state_q == bmfs_pkg::ST_EMIT) && out_free;

	// positions in use, saturated at the store depth
	assign lim = (count_q > bmfs_pkg::DEPTH_CNT) ? bmfs_pkg::DEPTH_CNT : count_q;

	// bounds of the current block, clamped to the positions in use
	assign blk_lo = CNT_W'({blk_q, {OFS_W{1'b0}}});
	always_comb begin
		blk_hi = blk_lo + bmfs_pkg::BLOCK_LEN_CNT;
		if (blk_hi > lim) begin
			blk_hi = lim;
		end
	end

	// one read issued per cycle while scanning
	assign issue = ((state_q == bmfs_pkg::ST_RESCAN) || (state_q == bmfs_pkg::ST_ESCAN))
		&& (idx_q < end_q);

	// shared signed compare: a >= b
	always_comb begin
		cmp_a = rd_data_q;
		cmp_b = val_q;
		case (state_q)
			bmfs_pkg::ST_RESCAN: begin
				cmp_a = max_q;
				cmp_b = rd_data_q;
			end
			bmfs_pkg::ST_BSCAN: begin
				cmp_a = bmax_q[blk_q];
				cmp_b = val_q;
			end
			default: begin
				cmp_a = rd_data_q;
				cmp_b = val_q;
			end
		endcase
	end
	assign cmp_ge = (cmp_a >= cmp_b);

	// memory write port: clearing pass or store of a write beat
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = val_q;
		case (state_q)
			bmfs_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[ADDR_W-1:0];
				mem_wdata = bmfs_pkg::MOST_NEG;
			end
			bmfs_pkg::ST_WRITE: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign bmax_we = (state_q == bmfs_pkg::ST_RESCAN) && !issue && !pend_q;

	// sequencer
	always_comb begin
		state_d     = state_q;
		blk_d       = blk_q;
		idx_d       = idx_q;
		end_d       = end_q;
		max_d       = max_q;
		hit_found_d = hit_found_q;
		hit_idx_d   = hit_idx_q;
		case (state_q)
			bmfs_pkg::ST_CLEAR: begin
				idx_d = idx_q + 1'b1;
				if (idx_q == bmfs_pkg::DEPTH_CNT - 1'b1) begin
					state_d = bmfs_pkg::ST_IDLE;
				end
			end
			bmfs_pkg::ST_IDLE: begin
				if (in_accept) begin
					blk_d       = '0;
					hit_found_d = 1'b0;
					hit_idx_d   = '0;
					if (command == bmfs_pkg::CMD_QUERY) begin
						state_d = bmfs_pkg::ST_BSCAN;
					end else if ({1'b0, position} < lim) begin
						state_d = bmfs_pkg::ST_WRITE;
					end
				end
			end
			bmfs_pkg::ST_WRITE: begin
				// set up the rescan of the written block
				blk_d = pos_q[ADDR_W-1:OFS_W];
				idx_d = CNT_W'({pos_q[ADDR_W-1:OFS_W], {OFS_W{1'b0}}});
				end_d = CNT_W'({pos_q[ADDR_W-1:OFS_W], {OFS_W{1'b0}}})
					+ bmfs_pkg::BLOCK_LEN_CNT;
				if (end_d > lim) begin
					end_d = lim;
				end
				max_d   = bmfs_pkg::MOST_NEG;
				state_d = bmfs_pkg::ST_RESCAN;
			end
			bmfs_pkg::ST_RESCAN: begin
				if (issue) begin
					idx_d = idx_q + 1'b1;
				end
				if (pend_q && !cmp_ge) begin
					max_d = rd_data_q;
				end
				if (!issue && !pend_q) begin
					state_d = bmfs_pkg::ST_IDLE;
				end
			end
			bmfs_pkg::ST_BSCAN: begin
				if (blk_lo >= lim) begin
					// past the positions in use: nothing left to find
					state_d = bmfs_pkg::ST_EMIT;
				end else if (cmp_ge) begin
					idx_d   = blk_lo;
					end_d   = blk_hi;
					state_d = bmfs_pkg::ST_ESCAN;
				end else if (blk_q == bmfs_pkg::LAST_BLK) begin
					state_d = bmfs_pkg::ST_EMIT;
				end else begin
					blk_d = blk_q + 1'b1;
				end
			end
			bmfs_pkg::ST_ESCAN: begin
				if (issue) begin
					idx_d = idx_q + 1'b1;
				end
				if (pend_q && cmp_ge) begin
					hit_found_d = 1'b1;
					hit_idx_d   = tag_q;
					state_d     = bmfs_pkg::ST_EMIT;
				end else if (!issue && !pend_q) begin
					// block held no qualifying element in use
					if (blk_q == bmfs_pkg::LAST_BLK) begin
						state_d = bmfs_pkg::ST_EMIT;
					end else begin
						blk_d   = blk_q + 1'b1;
						state_d = bmfs_pkg::ST_BSCAN;
					end
				end
			end
			bmfs_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = bmfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmfs_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmfs_pkg::ST_CLEAR;
			count_q     <= bmfs_pkg::COUNT_RESET;
			blk_q       <= '0;
			idx_q       <= '0;
			end_q       <= '0;
			pend_q      <= 1'b0;
			hit_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			blk_q       <= blk_d;
			idx_q       <= idx_d;
			end_q       <= end_d;
			pend_q      <= issue;
			hit_found_q <= hit_found_d;
			if (cfg_write_en) begin
				count_q <= cfg_write_data;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		max_q     <= max_d;
		hit_idx_q <= hit_idx_d;
		tag_q     <= idx_q[ADDR_W-1:0];
		if (in_accept) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= operand_value;
		end
		if (emit_load) begin
			found_q       <= hit_found_q;
			first_index_q <= hit_found_q ? hit_idx_q : '0;
		end
	end

	// block maxima, one per block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmfs_pkg::NUM_BLOCKS; i++) begin
				bmax_q[i] <= bmfs_pkg::MOST_NEG;
			end
		end else if (bmax_we && (cmd_q == bmfs_pkg::CMD_WRITE)) begin
			bmax_q[blk_q] <= max_q;
		end
	end

	// element memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			elem_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= elem_mem_q[idx_q[ADDR_W-1:0]];
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign first_index = first_index_q;

endmodule

FILE: tb/sv/tb_block_max_first_at_least_search_top.sv
`timescale 1ns / 1ps

module tb_block_max_first_at_least_search_top;

	localparam int DEPTH      = bmfs_pkg::DEPTH;
	localparam int BLOCK_LEN  = bmfs_pkg::BLOCK_LEN;
	localparam int NUM_BLOCKS = bmfs_pkg::NUM_BLOCKS;
	localparam int ADDR_W     = bmfs_pkg::ADDR_W;
	localparam int CNT_W      = bmfs_pkg::CNT_W;
	localparam int DATA_W     = bmfs_pkg::DATA_W;

	localparam logic [CNT_W-1:0]         DEPTH_CNT   = bmfs_pkg::DEPTH_CNT;
	localparam logic [CNT_W-1:0]         COUNT_RESET = bmfs_pkg::COUNT_RESET;
	localparam logic signed [DATA_W-1:0] MOST_NEG    = bmfs_pkg::MOST_NEG;
	localparam logic                     CMD_WRITE   = bmfs_pkg::CMD_WRITE;
	localparam logic                     CMD_QUERY   = bmfs_pkg::CMD_QUERY;

	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int SETTLE       = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 100;
	localparam int REPORT_LIMIT = 10;

	localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] pos;
		logic [DATA_W-1:0] val;
	} beat_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] spot;
	} hit_t;

	// DUT connections
	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     cfg_write_en   = 1'b0;
	logic [CNT_W-1:0]         cfg_write_data = '0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic                     command        = CMD_WRITE;
	logic [ADDR_W-1:0]        position       = '0;
	logic signed [DATA_W-1:0] operand_value  = '0;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic                     found;
	logic [ADDR_W-1:0]        first_index;

	// stimulus and scoreboard
	beat_t       pending_beats[$];
	hit_t        expected_hits[$];
	logic [31:0] written_values[$];
	logic        in_taken       = 1'b0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	int          hold_req       = 0;
	int          hold_ack       = 0;
	int          hold_left      = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	// mirror of the array, block maxima and element count
	logic signed [DATA_W-1:0] mirror_cells [DEPTH];
	logic signed [DATA_W-1:0] mirror_peak  [NUM_BLOCKS];
	logic [CNT_W-1:0]         mirror_count;

	block_max_first_at_least_search_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.position       (position),
		.operand_value  (operand_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.first_index    (first_index)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// positions in use, saturated at the array depth
	function automatic int live_span();
		return (mirror_count > DEPTH_CNT) ? DEPTH : int'(mirror_count);
	endfunction

	// store a word and recompute the maximum of its block
	function automatic void store_word(logic [ADDR_W-1:0] pos, logic signed [DATA_W-1:0] val);
		int lo;
		int hi;
		logic signed [DATA_W-1:0] peak;
		if (int'(pos) >= live_span())
			return;
		mirror_cells[pos] = val;
		lo = (int'(pos) / BLOCK_LEN) * BLOCK_LEN;
		hi = lo + BLOCK_LEN;
		if (hi > live_span())
			hi = live_span();
		peak = MOST_NEG;
		for (int j = lo; j < hi; j++)
			if (mirror_cells[j] > peak)
				peak = mirror_cells[j];
		mirror_peak[lo / BLOCK_LEN] = peak;
	endfunction

	// walk the block maxima, then scan each qualifying block
	function automatic hit_t first_at_least(logic signed [DATA_W-1:0] thr);
		hit_t r;
		int lim;
		r = '0;
		lim = live_span();
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			if (mirror_peak[b] < thr)
				continue;
			for (int j = b * BLOCK_LEN; j < (b + 1) * BLOCK_LEN && j < lim; j++) begin
				if (mirror_cells[j] >= thr) begin
					r.hit  = 1'b1;
					r.spot = ADDR_W'(j);
					return r;
				end
			end
		end
		return r;
	endfunction

	function automatic void queue_beat(logic cmd, int pos, logic [DATA_W-1:0] val);
		beat_t b;
		b.cmd = cmd;
		b.pos = ADDR_W'(pos);
		b.val = val;
		pending_beats = {pending_beats, b};
	endfunction

	// extremes, a narrow band around zero, or anything
	function automatic logic [DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 12) begin
			case ($urandom_range(3))
				0: return MOST_NEG;
				1: return MOST_POS;
				2: return '1;
				default: return '0;
			endcase
		end
		if (sel < 55)
			return 32'($urandom_range(2000)) - 32'd1000;
		return $urandom;
	endfunction

	// writes land mostly in range; thresholds mostly track written values
	function automatic beat_t make_beat();
		beat_t b;
		int span;
		span = live_span();
		b.pos = ADDR_W'($urandom);
		if ($urandom_range(99) < 55) begin
			b.cmd = CMD_WRITE;
			b.val = pick_value();
			if (span > 0 && $urandom_range(99) < 88)
				b.pos = ADDR_W'($urandom_range(span - 1));
			if (written_values.size() >= 64)
				void'(written_values.pop_front());
			written_values = {written_values, b.val};
		end else begin
			b.cmd = CMD_QUERY;
			if (written_values.size() != 0 && $urandom_range(99) < 60)
				b.val = written_values[$urandom_range(written_values.size() - 1)]
					+ 32'($urandom_range(2)) - 32'd1;
			else
				b.val = pick_value();
		end
		return b;
	endfunction

	function automatic logic [CNT_W-1:0] phase_count(int p);
		case (p)
			0: return COUNT_RESET;
			1: return 11'd45;
			2: return 11'd1;
			3: return 11'd0;
			4: return 11'd2047;
			5: return 11'd700;
			6: return 11'd33;
			default: return COUNT_RESET;
		endcase
	endfunction

	task automatic set_element_count(logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		mirror_count = v;
	endtask

	// wait for every beat to be taken and every result to come back
	task automatic drain();
		while (pending_beats.size() != 0 || in_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// input handshake seen at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// driver: hold a stalled beat, otherwise maybe send the next one
	always @(negedge clk) begin
		beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			nxt = pending_beats.pop_front();
			in_valid      <= 1'b1;
			command       <= nxt.cmd;
			position      <= nxt.pos;
			operand_value <= nxt.val;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: update the mirror on each input beat, check each result beat
	always @(posedge clk) begin
		hit_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (command == CMD_QUERY)
					expected_hits = {expected_hits, first_at_least(operand_value)};
				else
					store_word(position, operand_value);
			end
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result beat: found=%0b first_index=%0d",
							found, first_index);
				end else begin
					want = expected_hits.pop_front();
					if (found !== want.hit || first_index !== want.spot) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: exp found=%0b first_index=%0d, got found=%0b first_index=%0d",
								want.hit, want.spot, found, first_index);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_block_max_first_at_least_search_top: done, errors");
			$finish;
		end
	end

	initial begin
		int span;
		for (int i = 0; i < DEPTH; i++)
			mirror_cells[i] = MOST_NEG;
		for (int i = 0; i < NUM_BLOCKS; i++)
			mirror_peak[i] = MOST_NEG;
		mirror_count  = COUNT_RESET;
		send_idle_pct = 20;
		recv_idle_pct = 46;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty array, extremes, block edges, overwrite that lowers a maximum
		queue_beat(CMD_QUERY, 0, MOST_NEG);
		queue_beat(CMD_QUERY, 0, MOST_POS);
		queue_beat(CMD_QUERY, 1023, '0);
		queue_beat(CMD_WRITE, 1023, MOST_POS);
		queue_beat(CMD_QUERY, 0, MOST_POS);
		queue_beat(CMD_WRITE, 0, MOST_NEG);
		queue_beat(CMD_QUERY, 0, MOST_NEG);
		queue_beat(CMD_WRITE, 31, '1);
		queue_beat(CMD_WRITE, 32, '0);
		queue_beat(CMD_QUERY, 0, '1);
		queue_beat(CMD_QUERY, 0, '0);
		queue_beat(CMD_QUERY, 0, 32'd1);
		queue_beat(CMD_WRITE, 512, 32'h1234_5678);
		queue_beat(CMD_QUERY, 0, 32'h1234_5678);
		queue_beat(CMD_WRITE, 1, 32'd5);
		queue_beat(CMD_QUERY, 0, 32'd5);
		queue_beat(CMD_WRITE, 1, MOST_NEG);
		queue_beat(CMD_QUERY, 0, '1);
		queue_beat(CMD_WRITE, 700, 32'h7fff_fffe);
		queue_beat(CMD_QUERY, 0, 32'h7fff_fffe);
		queue_beat(CMD_QUERY, 1023, '0);
		queue_beat(CMD_QUERY, 682, 32'h8000_0001);

		// phases over element counts, with changing idle patterns
		for (int p = 0; p < PHASES; p++) begin
			drain();
			send_idle_pct = (p < 3) ? 20 : (p < 6) ? 46 : 0;
			recv_idle_pct = (p < 3) ? 46 : (p < 6) ? 20 : 0;
			set_element_count(phase_count(p));
			span = live_span();
			queue_beat(CMD_QUERY, $urandom_range(1023), MOST_NEG);
			queue_beat(CMD_WRITE, (span > 0) ? span - 1 : 0, MOST_POS);
			if (span < DEPTH)
				queue_beat(CMD_WRITE, span, MOST_POS);
			queue_beat(CMD_QUERY, 0, MOST_POS);
			for (int i = 0; i < PHASE_BEATS; i++)
				pending_beats = {pending_beats, make_beat()};
			// long receiver hold-off so the block backs up into its input
			if (p == 0)
				hold_req++;
		end

		drain();
		mismatch_count += expected_hits.size();
		if (mismatch_count == 0)
			$display("tb_block_max_first_at_least_search_top: done, clean");
		else
			$display("tb_block_max_first_at_least_search_top: done, errors");
		$finish;
	end

endmodule

FILE: files.f
hdl/bmfs_pkg.sv
hdl/block_max_first_at_least_search_top.sv
tb/sv/tb_block_max_first_at_least_search_top.sv
